// ===== rtl/mtt_pkg.sv =====
// Shared types, constants and status codes for the timer table.
`default_nettype none

package mtt_pkg;

    // Default capacity of the timer table.
    localparam int MAX_TIMERS_DEF = 16;

    // Most fired results reported for one tick.
    localparam int RESULT_CAP = 16;
    localparam int NREP_W     = $clog2(RESULT_CAP + 1);

    // Field widths of one timer entry.
    localparam int PERIOD_W = 16;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED = 2'd2;

    // Input item kinds.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // One stored timer.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
        logic [TAG_W-1:0]    tag;
        logic                once;
    } entry_t;

    // Control states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/mtt_item_if.sv =====
// Input channel carrying add and tick items.
`default_nettype none

interface mtt_item_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [mtt_pkg::PERIOD_W-1:0] period;
    logic [mtt_pkg::TAG_W-1:0]    tag;
    logic                        one_shot;

    modport source (output valid, output kind, output period, output tag,
                    output one_shot, input ready);
    modport sink   (input valid, input kind, input period, input tag,
                    input one_shot, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtt_result_if.sv =====
// Output channel carrying add answers and fired timer results.
`default_nettype none

interface mtt_result_if;
    logic                         valid;
    logic                         ready;
    logic [mtt_pkg::STATUS_W-1:0] status;
    logic [mtt_pkg::TAG_W-1:0]    fired_tag;
    logic                         last;

    modport source (output valid, output status, output fired_tag, output last,
                    input ready);
    modport sink   (input valid, input status, input fired_tag, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/multi_timer_table.sv =====
// Timer table: up to MAX_TIMERS timers in insertion order, stored in one synchronous memory.
//
// An add item answers with exactly one result (accepted or full, last set).
// A tick walks the stored timers through the single memory read port, one entry per cycle
// unless a firing must wait for a busy output. The entries are read in order, each one is
// processed from the registered read data, and after the last one the walk closes and
// loads the final result; only then can the next item be transferred. Each entry is read,
// its count advanced, and it is written back in compacted position, so one-shot timers
// that fire drop out while the order of the others is kept. Fired results are held back
// by one so that the final one of a tick carries last; a tick in which nothing fires gives
// no result. New items are taken only between ticks, when the output register is free or
// being emptied.
`default_nettype none

module multi_timer_table #(
    parameter int MAX_TIMERS = mtt_pkg::MAX_TIMERS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    mtt_item_if.sink     items,
    mtt_result_if.source results
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // Timer memory with registered read data.
    mtt_pkg::entry_t mem [MAX_TIMERS];
    mtt_pkg::entry_t rdata_reg;
    logic            mem_we;
    logic [IDX_W-1:0] mem_wa;
    mtt_pkg::entry_t mem_wd;
    logic            mem_re;
    logic [IDX_W-1:0] mem_ra;

    // Control and walk state.
    mtt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic             proc_v_reg, proc_v_next;
    logic             pend_v_reg, pend_v_next;
    logic [mtt_pkg::TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    logic [mtt_pkg::NREP_W-1:0] nrep_reg, nrep_next;

    // Output register.
    logic                         out_v_reg, out_v_next;
    logic [mtt_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [mtt_pkg::TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_load;

    // Per-entry update terms.
    logic                          out_free;
    logic                          in_xfer;
    logic [mtt_pkg::PERIOD_W-1:0]  cnt_inc;
    logic                          fire;
    logic                          keep;
    logic                          report;
    logic                          stall;
    logic                          advance;
    logic                          issue;
    logic                          walk_done;
    mtt_pkg::entry_t               upd_entry;
    mtt_pkg::entry_t               add_entry;

    // Handshake terms.
    assign out_free    = !out_v_reg || results.ready;
    assign items.ready = (state_reg == mtt_pkg::S_IDLE) && out_free;
    assign in_xfer     = items.valid && items.ready;

    assign results.valid     = out_v_reg;
    assign results.status    = out_status_reg;
    assign results.fired_tag = out_tag_reg;
    assign results.last      = out_last_reg;

    // Count update of the entry in the processing stage; the count saturates.
    assign cnt_inc = (rdata_reg.count != '1) ? rdata_reg.count + 16'd1 : rdata_reg.count;
    assign fire    = (rdata_reg.period != '0) && (cnt_inc == rdata_reg.period);
    assign keep    = !(fire && rdata_reg.once);
    assign report  = proc_v_reg && fire && (nrep_reg < mtt_pkg::NREP_W'(mtt_pkg::RESULT_CAP));

    always_comb
    begin
        upd_entry        = rdata_reg;
        upd_entry.count  = fire ? '0 : cnt_inc;
        add_entry.period = items.period;
        add_entry.count  = '0;
        add_entry.tag    = items.tag;
        add_entry.once   = items.one_shot;
    end

    // The walk halts when a new firing must push the held result into a busy output.
    assign stall     = report && pend_v_reg && !out_free;
    assign advance   = (state_reg == mtt_pkg::S_WALK) && !stall;
    assign issue     = advance && (rd_idx_reg < used_reg);
    assign walk_done = (state_reg == mtt_pkg::S_WALK) && !proc_v_reg && (rd_idx_reg == used_reg);

    assign mem_re = issue;
    assign mem_ra = rd_idx_reg[IDX_W-1:0];

    // Next-state logic for control, memory writes and the output register.
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        proc_v_next     = proc_v_reg;
        pend_v_next     = pend_v_reg;
        pend_tag_next   = pend_tag_reg;
        nrep_next       = nrep_reg;
        mem_we          = 1'b0;
        mem_wa          = wr_idx_reg[IDX_W-1:0];
        mem_wd          = upd_entry;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            mtt_pkg::S_IDLE:
            begin
                if (in_xfer && (items.kind == mtt_pkg::KIND_ADD))
                begin
                    out_load      = 1'b1;
                    out_tag_next  = '0;
                    out_last_next = 1'b1;
                    if (used_reg < CNT_W'(MAX_TIMERS))
                    begin
                        out_status_next = mtt_pkg::ST_OK;
                        mem_we          = 1'b1;
                        mem_wa          = used_reg[IDX_W-1:0];
                        mem_wd          = add_entry;
                        used_next       = used_reg + 1'b1;
                    end
                    else
                    begin
                        out_status_next = mtt_pkg::ST_FULL;
                    end
                end
                else if (in_xfer && (used_reg != '0))
                begin
                    state_next  = mtt_pkg::S_WALK;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    nrep_next   = '0;
                    pend_v_next = 1'b0;
                    proc_v_next = 1'b0;
                end
            end
            mtt_pkg::S_WALK:
            begin
                if (advance)
                begin
                    proc_v_next = issue;
                    if (issue)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    // Write back the kept entry in its compacted place.
                    if (proc_v_reg && keep)
                    begin
                        mem_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                    // A new firing pushes out the held one, which is then not the last.
                    if (report)
                    begin
                        nrep_next     = nrep_reg + 1'b1;
                        pend_v_next   = 1'b1;
                        pend_tag_next = rdata_reg.tag;
                        if (pend_v_reg)
                        begin
                            out_load        = 1'b1;
                            out_status_next = mtt_pkg::ST_FIRED;
                            out_tag_next    = pend_tag_reg;
                            out_last_next   = 1'b0;
                        end
                    end
                end
                // End of the walk: release the held firing as the last result.
                if (walk_done && (!pend_v_reg || out_free))
                begin
                    state_next  = mtt_pkg::S_IDLE;
                    used_next   = wr_idx_reg;
                    pend_v_next = 1'b0;
                    if (pend_v_reg)
                    begin
                        out_load        = 1'b1;
                        out_status_next = mtt_pkg::ST_FIRED;
                        out_tag_next    = pend_tag_reg;
                        out_last_next   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = mtt_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    // Timer memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mtt_pkg::S_IDLE;
            used_reg   <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            proc_v_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            nrep_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            proc_v_reg <= proc_v_next;
            pend_v_reg <= pend_v_next;
            nrep_reg   <= nrep_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_tag_reg   <= pend_tag_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mtt_checker.sv =====
// Port-level assertions for the timer table, and the bind that attaches them.
`default_nettype none

module mtt_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         in_kind,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [mtt_pkg::STATUS_W-1:0] out_status,
    input wire [mtt_pkg::TAG_W-1:0]    out_tag,
    input wire                         out_last
);

    // A waiting result stays offered until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // A waiting result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_tag) && $stable(out_last))
        else $error("result payload changed while stalled");

    // An add transfer is answered in the next cycle by a single final add result.
    a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == mtt_pkg::KIND_ADD) |=>
        out_valid && out_last && (out_status != mtt_pkg::ST_FIRED))
        else $error("add item not answered by one final result");

    // Add answers carry a zero tag and close their item.
    a_add_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != mtt_pkg::ST_FIRED) |-> out_last && (out_tag == '0))
        else $error("add answer with tag or without last");

    // After a non-final firing, the input opens only once the final firing is on offer.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_status == mtt_pkg::ST_FIRED) && !out_last |=>
        !in_ready || (out_valid && (out_status == mtt_pkg::ST_FIRED) && out_last))
        else $error("input taken in the middle of a tick");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .in_kind    (items.kind),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_status (results.status),
    .out_tag    (results.fired_tag),
    .out_last   (results.last)
);

`default_nettype wire
